[hdl/fuzzy_controller_3_input_macros.svh]
// ----------------------------------------------------------------------------
// Fuzzy controller assertion macros
// Shorthands for clocked implication checks that a reset disables.
// ----------------------------------------------------------------------------
`ifndef FUZZY_CONTROLLER_3_INPUT_MACROS_SVH
`define FUZZY_CONTROLLER_3_INPUT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FC3_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fuzzy controller check failed");

// The consequent must hold in the cycle after the antecedent.
`define FC3_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fuzzy controller check failed");

`endif

[hdl/fc3_pkg.sv]
// ----------------------------------------------------------------------------
// Fuzzy controller package
// Widths, codes and the grading and defuzzification functions.
// ----------------------------------------------------------------------------
`default_nettype none

package fc3_pkg;

   localparam int SAMPLE_WIDTH     = 16;
   localparam int ACCUM_WIDTH      = 20;
   localparam int RESULT_WIDTH     = 20;
   localparam int LEVEL_WIDTH      = 4;
   localparam int RULE_INDEX_WIDTH = 9;
   localparam int RULE_DEPTH       = 343;
   localparam int GRADE_MAX        = 3;
   localparam int GRADE_COUNT      = 2 * GRADE_MAX + 1;
   localparam int GRADE_WIDTH      = 3;
   localparam int LEVEL_CAP        = 6;
   localparam int THRESH_WIDTH     = 15;
   localparam int THRESH_COUNT     = 3;
   localparam int DEFUZZ_WIDTH     = 12;
   localparam int DEFUZZ_COUNT     = 5;
   localparam int CRISP_WIDTH      = DEFUZZ_WIDTH + 1;
   localparam int OFFSET_WIDTH     = 16;
   localparam int OPCODE_WIDTH     = 2;
   localparam int CSR_INDEX_WIDTH  = 3;
   localparam int CSR_DATA_WIDTH   = DEFUZZ_WIDTH * DEFUZZ_COUNT;

   // Diff of two samples needs one more bit than a sample.
   localparam int DIFF_WIDTH  = SAMPLE_WIDTH + 1;
   localparam int FSUM_WIDTH  = ACCUM_WIDTH + 1;
   localparam int RSUM_BASE   = (ACCUM_WIDTH > RESULT_WIDTH) ? ACCUM_WIDTH : RESULT_WIDTH;
   localparam int RSUM_WIDTH  = RSUM_BASE + 2;
   localparam int MAG_BASE    = (DIFF_WIDTH > ACCUM_WIDTH) ? DIFF_WIDTH : ACCUM_WIDTH;
   localparam int MAG_WIDTH   = (MAG_BASE > THRESH_WIDTH) ? MAG_BASE : THRESH_WIDTH;

   typedef enum logic [OPCODE_WIDTH-1:0] {
      OP_STEP  = 2'd0,
      OP_WRITE = 2'd1,
      OP_CLEAR = 2'd2
   } op_type;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_ERROR_THRESH = 3'd0,
      CSR_DIFF_THRESH  = 3'd1,
      CSR_FORCE_THRESH = 3'd2,
      CSR_DEFUZZ       = 3'd3,
      CSR_OFFSET       = 3'd4
   } csr_index_type;

   typedef logic [GRADE_WIDTH-1:0]                 grade_index_type;
   typedef logic [THRESH_COUNT*THRESH_WIDTH-1:0]   thresh_set_type;
   typedef logic [DEFUZZ_COUNT*DEFUZZ_WIDTH-1:0]   defuzz_set_type;

   // Grade a magnitude against three thresholds and return the grade offset
   // by GRADE_MAX, so that 0 is the most negative grade.
   function automatic grade_index_type grade_index(input logic neg,
                                                   input logic [MAG_WIDTH-1:0] mag,
                                                   input thresh_set_type thr);
      logic [GRADE_WIDTH-1:0] g;
      if (mag > MAG_WIDTH'(thr[2*THRESH_WIDTH +: THRESH_WIDTH])) begin
         g = GRADE_WIDTH'(GRADE_MAX);
      end else if (mag > MAG_WIDTH'(thr[THRESH_WIDTH +: THRESH_WIDTH])) begin
         g = GRADE_WIDTH'(2);
      end else if (mag > MAG_WIDTH'(thr[0 +: THRESH_WIDTH])) begin
         g = GRADE_WIDTH'(1);
      end else begin
         g = '0;
      end
      return neg ? GRADE_WIDTH'(GRADE_MAX) - g : GRADE_WIDTH'(GRADE_MAX) + g;
   endfunction

   // Map a signed rule level to a signed crisp output.
   function automatic logic signed [CRISP_WIDTH-1:0] defuzzify(
         input logic signed [LEVEL_WIDTH-1:0] level,
         input defuzz_set_type levels);
      logic [LEVEL_WIDTH-1:0]  mag;
      logic [2:0]              slot;
      logic [DEFUZZ_WIDTH-1:0] d;
      logic [CRISP_WIDTH-1:0]  d_ext;
      mag  = level[LEVEL_WIDTH-1] ? LEVEL_WIDTH'(-level) : LEVEL_WIDTH'(level);
      slot = 3'(DEFUZZ_COUNT - 1);
      case (mag) inside
         [4'd1:4'(LEVEL_CAP - 1)]: slot = 3'(mag - 4'd1);
         default:                  slot = 3'(DEFUZZ_COUNT - 1);
      endcase
      d     = levels[slot*DEFUZZ_WIDTH +: DEFUZZ_WIDTH];
      d_ext = {1'b0, d};
      if (mag == '0) begin
         return '0;
      end
      return level[LEVEL_WIDTH-1] ? $signed(-d_ext) : $signed(d_ext);
   endfunction

endpackage

`default_nettype wire

[hdl/fc3_channels.sv]
// ----------------------------------------------------------------------------
// Fuzzy controller channels
// Valid/ready interfaces for requests, results and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface fc3_req_if;
   logic                                          valid;
   logic                                          ready;
   logic [fc3_pkg::OPCODE_WIDTH-1:0]              opcode;
   logic signed [fc3_pkg::SAMPLE_WIDTH-1:0]       error_sample;
   logic [fc3_pkg::RULE_INDEX_WIDTH-1:0]          rule_index;
   logic signed [fc3_pkg::LEVEL_WIDTH-1:0]        rule_level;

   modport source (output valid, opcode, error_sample, rule_index, rule_level,
                   input ready);
   modport sink   (input valid, opcode, error_sample, rule_index, rule_level,
                   output ready);
endinterface

interface fc3_rsp_if;
   logic                                          valid;
   logic                                          ready;
   logic signed [fc3_pkg::RESULT_WIDTH-1:0]       control_result;
   logic signed [fc3_pkg::LEVEL_WIDTH-1:0]        fuzzy_level;
   logic                                          saturated;

   modport source (output valid, control_result, fuzzy_level, saturated,
                   input ready);
   modport sink   (input valid, control_result, fuzzy_level, saturated,
                   output ready);
endinterface

interface fc3_csr_if;
   logic                                          valid;
   logic                                          ready;
   logic [fc3_pkg::CSR_INDEX_WIDTH-1:0]           reg_index;
   logic [fc3_pkg::CSR_DATA_WIDTH-1:0]            wr_data;

   modport source (output valid, reg_index, wr_data, input ready);
   modport sink   (input valid, reg_index, wr_data, output ready);
endinterface

`default_nettype wire

[hdl/fuzzy_controller_3_input.sv]
// ----------------------------------------------------------------------------
// Three-input fuzzy controller
// Grades error, diff and force, looks up a rule memory and defuzzifies.
// ----------------------------------------------------------------------------
// In the cycle a control step request is accepted, the error, the diff and the
// saturated force accumulator are graded and the rule memory read is launched;
// in the next cycle the registered rule level is defuzzified and the result is
// formed, and when the second stage moves, the result enters the output
// register and the crisp output is stored back for the following step. The
// result is valid on the response channel from the output register. Because
// the next step's force depends on this step's crisp output, the request
// channel is not ready while the second stage holds a control step, which it
// leaves as soon as the output register can take the result; so a new control
// step is not accepted before the last one has left the second stage. Rule
// writes, clears and unknown opcodes produce no response and are taken one per
// cycle while the second stage holds no control step. A finished result may
// wait in the output register while the next request is accepted; a control
// step accepted behind it then stays in the second stage, and the request
// channel stays stalled until the waiting result is taken.
// The rule memory is not cleared by reset; every entry that a control step
// can address must be written first. Register writes are always accepted and
// are meant to happen while idle.
// ----------------------------------------------------------------------------
`default_nettype none

`include "fuzzy_controller_3_input_macros.svh"

module fuzzy_controller_3_input (
   input  wire          clock,
   input  wire          reset,
   fc3_req_if.sink      req_bus,
   fc3_rsp_if.source    rsp_bus,
   fc3_csr_if.sink      csr_bus
);

   // Configuration registers.
   fc3_pkg::thresh_set_type                     error_thr_ff;
   fc3_pkg::thresh_set_type                     diff_thr_ff;
   fc3_pkg::thresh_set_type                     force_thr_ff;
   fc3_pkg::defuzz_set_type                     defuzz_ff;
   logic signed [fc3_pkg::OFFSET_WIDTH-1:0]     offset_ff;

   // Controller state.
   logic signed [fc3_pkg::SAMPLE_WIDTH-1:0]     prev_err_ff;
   logic signed [fc3_pkg::ACCUM_WIDTH-1:0]      force_sum_ff;
   logic signed [fc3_pkg::CRISP_WIDTH-1:0]      prev_out_ff;

   // Rule memory and its registered read data.
   logic signed [fc3_pkg::LEVEL_WIDTH-1:0]      rule_mem [fc3_pkg::RULE_DEPTH];
   logic signed [fc3_pkg::LEVEL_WIDTH-1:0]      rule_rd_ff;

   // Second stage and output register.
   logic                                        s1_valid_ff;
   logic                                        s1_fsat_ff;
   logic                                        rsp_valid_ff;
   logic signed [fc3_pkg::RESULT_WIDTH-1:0]     control_result_ff;
   logic signed [fc3_pkg::LEVEL_WIDTH-1:0]      fuzzy_level_ff;
   logic                                        saturated_ff;

   logic                                        req_hs;
   logic                                        step_acc;
   logic                                        write_acc;
   logic                                        clear_acc;
   logic                                        s1_move;
   logic                                        csr_hs;

   logic signed [fc3_pkg::DIFF_WIDTH-1:0]       e_ext;
   logic signed [fc3_pkg::DIFF_WIDTH-1:0]       diff;
   logic signed [fc3_pkg::FSUM_WIDTH-1:0]       fsum_wide;
   logic                                        force_clip;
   logic signed [fc3_pkg::ACCUM_WIDTH-1:0]      force_in;
   logic signed [fc3_pkg::MAG_WIDTH-1:0]        e_wide;
   logic signed [fc3_pkg::MAG_WIDTH-1:0]        d_wide;
   logic signed [fc3_pkg::MAG_WIDTH-1:0]        f_wide;
   logic [fc3_pkg::MAG_WIDTH-1:0]               e_mag;
   logic [fc3_pkg::MAG_WIDTH-1:0]               d_mag;
   logic [fc3_pkg::MAG_WIDTH-1:0]               f_mag;
   fc3_pkg::grade_index_type                    eg;
   fc3_pkg::grade_index_type                    dg;
   fc3_pkg::grade_index_type                    fg;
   logic [fc3_pkg::RULE_INDEX_WIDTH-1:0]        rd_addr;

   logic signed [fc3_pkg::CRISP_WIDTH-1:0]      crisp;
   logic signed [fc3_pkg::RSUM_WIDTH-1:0]       rsum;
   logic [fc3_pkg::RSUM_WIDTH-fc3_pkg::RESULT_WIDTH:0] rsum_top;
   logic                                        result_clip;
   logic signed [fc3_pkg::RESULT_WIDTH-1:0]     result_in;

   // ------------------------------------------------------------------------
   // Handshakes. The request channel stalls only while the second stage
   // still holds a control step.
   // ------------------------------------------------------------------------
   assign req_bus.ready = !s1_valid_ff;
   assign csr_bus.ready = 1'b1;
   assign req_hs        = req_bus.valid && req_bus.ready;
   assign csr_hs        = csr_bus.valid && csr_bus.ready;
   assign step_acc      = req_hs && (req_bus.opcode == fc3_pkg::OP_STEP);
   assign write_acc     = req_hs && (req_bus.opcode == fc3_pkg::OP_WRITE) &&
                          (req_bus.rule_index < fc3_pkg::RULE_INDEX_WIDTH'(fc3_pkg::RULE_DEPTH));
   assign clear_acc     = req_hs && (req_bus.opcode == fc3_pkg::OP_CLEAR);
   assign s1_move       = s1_valid_ff && (!rsp_valid_ff || rsp_bus.ready);

   // ------------------------------------------------------------------------
   // First stage: diff, force accumulation with saturation, grading and the
   // rule address.
   // ------------------------------------------------------------------------
   always_comb begin
      e_ext      = fc3_pkg::DIFF_WIDTH'(req_bus.error_sample);
      diff       = fc3_pkg::DIFF_WIDTH'(prev_err_ff) - e_ext;
      fsum_wide  = fc3_pkg::FSUM_WIDTH'(force_sum_ff) + fc3_pkg::FSUM_WIDTH'(prev_out_ff);

      // The sum overflowed when its two top bits differ.
      force_clip = fsum_wide[fc3_pkg::ACCUM_WIDTH] != fsum_wide[fc3_pkg::ACCUM_WIDTH-1];
      if (force_clip) begin
         force_in = {fsum_wide[fc3_pkg::ACCUM_WIDTH],
                     {(fc3_pkg::ACCUM_WIDTH-1){~fsum_wide[fc3_pkg::ACCUM_WIDTH]}}};
      end else begin
         force_in = fsum_wide[fc3_pkg::ACCUM_WIDTH-1:0];
      end

      e_wide = fc3_pkg::MAG_WIDTH'(req_bus.error_sample);
      d_wide = fc3_pkg::MAG_WIDTH'(diff);
      f_wide = fc3_pkg::MAG_WIDTH'(force_in);
      e_mag  = e_wide[fc3_pkg::MAG_WIDTH-1] ? fc3_pkg::MAG_WIDTH'(-e_wide) : e_wide;
      d_mag  = d_wide[fc3_pkg::MAG_WIDTH-1] ? fc3_pkg::MAG_WIDTH'(-d_wide) : d_wide;
      f_mag  = f_wide[fc3_pkg::MAG_WIDTH-1] ? fc3_pkg::MAG_WIDTH'(-f_wide) : f_wide;

      eg = fc3_pkg::grade_index(e_wide[fc3_pkg::MAG_WIDTH-1], e_mag, error_thr_ff);
      dg = fc3_pkg::grade_index(d_wide[fc3_pkg::MAG_WIDTH-1], d_mag, diff_thr_ff);
      fg = fc3_pkg::grade_index(f_wide[fc3_pkg::MAG_WIDTH-1], f_mag, force_thr_ff);

      rd_addr = fc3_pkg::RULE_INDEX_WIDTH'(fg) *
                   fc3_pkg::RULE_INDEX_WIDTH'(fc3_pkg::GRADE_COUNT * fc3_pkg::GRADE_COUNT) +
                fc3_pkg::RULE_INDEX_WIDTH'(dg) *
                   fc3_pkg::RULE_INDEX_WIDTH'(fc3_pkg::GRADE_COUNT) +
                fc3_pkg::RULE_INDEX_WIDTH'(eg);
   end

   // ------------------------------------------------------------------------
   // Rule memory: one write port for rule loads, one registered read port for
   // control steps. A write and a read never fall in the same cycle, and a
   // read in the cycle after a write already sees the new entry.
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (write_acc) begin
         rule_mem[req_bus.rule_index] <= req_bus.rule_level;
      end
      if (step_acc) begin
         rule_rd_ff <= rule_mem[rd_addr];
      end
   end

   // ------------------------------------------------------------------------
   // Second stage: defuzzify the looked-up level and form the saturated
   // result from offset, force and crisp output.
   // ------------------------------------------------------------------------
   always_comb begin
      crisp    = fc3_pkg::defuzzify(rule_rd_ff, defuzz_ff);
      rsum     = fc3_pkg::RSUM_WIDTH'(offset_ff) + fc3_pkg::RSUM_WIDTH'(force_sum_ff) +
                 fc3_pkg::RSUM_WIDTH'(crisp);
      // The result fits when every bit from the result's sign bit up agrees.
      rsum_top    = rsum[fc3_pkg::RSUM_WIDTH-1:fc3_pkg::RESULT_WIDTH-1];
      result_clip = !((&rsum_top) || !(|rsum_top));
      if (result_clip) begin
         result_in = {rsum[fc3_pkg::RSUM_WIDTH-1],
                      {(fc3_pkg::RESULT_WIDTH-1){~rsum[fc3_pkg::RSUM_WIDTH-1]}}};
      end else begin
         result_in = rsum[fc3_pkg::RESULT_WIDTH-1:0];
      end
   end

   // ------------------------------------------------------------------------
   // Control state, configuration and pipeline valid bits.
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         error_thr_ff  <= '0;
         diff_thr_ff   <= '0;
         force_thr_ff  <= '0;
         defuzz_ff     <= '0;
         offset_ff     <= '0;
         prev_err_ff   <= '0;
         force_sum_ff  <= '0;
         prev_out_ff   <= '0;
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_hs) begin
            case (fc3_pkg::csr_index_type'(csr_bus.reg_index))
               fc3_pkg::CSR_ERROR_THRESH: error_thr_ff <= csr_bus.wr_data[$bits(error_thr_ff)-1:0];
               fc3_pkg::CSR_DIFF_THRESH:  diff_thr_ff  <= csr_bus.wr_data[$bits(diff_thr_ff)-1:0];
               fc3_pkg::CSR_FORCE_THRESH: force_thr_ff <= csr_bus.wr_data[$bits(force_thr_ff)-1:0];
               fc3_pkg::CSR_DEFUZZ:       defuzz_ff    <= csr_bus.wr_data[$bits(defuzz_ff)-1:0];
               fc3_pkg::CSR_OFFSET:       offset_ff    <= csr_bus.wr_data[fc3_pkg::OFFSET_WIDTH-1:0];
               default: begin
               end
            endcase
         end

         if (clear_acc) begin
            prev_err_ff  <= '0;
            force_sum_ff <= '0;
            prev_out_ff  <= '0;
         end else if (step_acc) begin
            prev_err_ff  <= req_bus.error_sample;
            force_sum_ff <= force_in;
         end else if (s1_move) begin
            prev_out_ff  <= crisp;
         end

         if (step_acc) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_move) begin
            s1_valid_ff <= 1'b0;
         end

         if (s1_move) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (step_acc) begin
         s1_fsat_ff <= force_clip;
      end
      if (s1_move) begin
         control_result_ff <= result_in;
         fuzzy_level_ff    <= rule_rd_ff;
         saturated_ff      <= s1_fsat_ff || result_clip;
      end
   end

   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.control_result = control_result_ff;
   assign rsp_bus.fuzzy_level    = fuzzy_level_ff;
   assign rsp_bus.saturated      = saturated_ff;

   // ------------------------------------------------------------------------
   // Assertions.
   // ------------------------------------------------------------------------
   `FC3_ASSERT_NEXT(a_step_enters_stage, clock, reset, step_acc, s1_valid_ff)
   `FC3_ASSERT_NEXT(a_stage_fills_output, clock, reset, s1_move, rsp_valid_ff)
   `FC3_ASSERT_NEXT(a_clear_zeroes_state, clock, reset, clear_acc, (force_sum_ff == '0) && (prev_out_ff == '0) && (prev_err_ff == '0))
   `FC3_ASSERT_SAME(a_no_response_from_idle, clock, reset, s1_move, !step_acc)

endmodule

`default_nettype wire
